>>> sv/tpmra_pkg.sv
// Package for the temporary page-map ring allocator: sizes, slot entry layout,
// sequencer state type and the cpu number folding function.
// No dependencies; used by temp_page_map_ring_allocator.
package tpmra_pkg;

    localparam int SLOTS     = 1024;
    localparam int CPUS      = 8;
    localparam int PAGE_BITS = 12;

    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int CPU_W     = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int FRAME_W   = 32 - PAGE_BITS;
    localparam int ENTRY_W   = FRAME_W + 2;

    localparam int SLOT_IDX_W = 10;
    localparam int CPU_ID_W   = 3;

    // Request kinds carried in tuser.
    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_UNMAP = 1'b1;

    // Slot entry: bit 0 present, bit 1 ready to recycle, frame number above.
    localparam int BIT_PRESENT = 0;
    localparam int BIT_READY   = 1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UNMAP_RD,
        S_UNMAP_WR,
        S_EPOCH,
        S_STEP,
        S_RECYCLE,
        S_CHECK,
        S_DONE
    } t_state;

    // Folds a cpu number into the range of implemented cpus by repeated
    // subtraction; the input is only three bits wide.
    function automatic logic [CPU_W-1:0] cpu_wrap(input logic [CPU_ID_W-1:0] c);
        logic [6:0] v;
        v = 7'(c);
        for (int k = 0; k < 8; k++) begin
            if (v >= 7'(CPUS)) begin
                v = v - 7'(CPUS);
            end
        end
        return CPU_W'(v);
    endfunction

endpackage

>>> sv/tpmra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the slot table of the page-map ring allocator; no dependencies.
module tpmra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/temp_page_map_ring_allocator.sv
// Temporary page-map ring allocator: top level with the slot sequencer.
// Depends on tpmra_pkg and tpmra_ram.
//
// An unmap reads its slot and then writes it back (only the read outside the
// window) and gives no result. A map checks the cpu epoch, then steps the ring
// index and checks slots until one is free, with a recycle sweep on a wrap.
// Throughput: one item at a time; the next transfer follows the previous result.
// Reset: synchronous, active low. After reset a clearing pass writes every
// slot table entry to zero before the first transfer.
module temp_page_map_ring_allocator
    import tpmra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration: window_base.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [31:0]           i_cfg_data,

    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] cpu_id, [34:3] phys_addr, [66:35] virt_addr, [71:67] zero.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] kind (0 = map, 1 = unmap).
    input  logic                  s_axis_tuser,

    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] mapped_addr, [41:32] slot_index, [42] tlb_flush, [47:43] zero.
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // [0] full_error.
    output logic                  m_axis_tuser
);

    // Sequencer state.
    t_state r_state;
    t_state n_state;

    // Shared sweep counter: clearing pass after reset and the recycle sweep.
    logic [ADDR_W:0]     r_sweep;
    logic                r_rd_pend;
    logic [ADDR_W-1:0]   r_rd_addr;

    // Latched request.
    logic [CPU_W-1:0]    r_cpu;
    logic [31:0]         r_pa;
    logic [31:0]         r_va;

    // Architectural state.
    logic [31:0]         r_base;
    logic [ADDR_W-1:0]   r_ring_idx;
    logic [31:0]         r_global_epoch;
    logic [31:0]         r_cpu_epoch [CPUS];

    // Per-request bookkeeping and the result being built.
    logic                r_wrapped;
    logic                r_flush;
    logic                r_full;
    logic [31:0]         r_res_addr;

    // Output register.
    logic                r_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic                r_m_tuser;

    // Slot table memory controls.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // Datapath helpers.
    logic [31:0]         unmap_off;
    logic                unmap_in_range;
    logic [ADDR_W-1:0]   unmap_idx;
    logic [ADDR_W-1:0]   idx_next;
    logic [63:0]         slot_off;
    logic [31:0]         map_addr;
    logic [ENTRY_W-1:0]  map_entry;
    logic                sweep_busy;
    logic                out_free;
    logic                in_xfer;

    tpmra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The slot under an unmap address is the page offset from the window
    // base; anything beyond the last slot is ignored.
    assign unmap_off      = r_va - r_base;
    assign unmap_in_range = (unmap_off >> PAGE_BITS) < 32'(SLOTS);
    assign unmap_idx      = ADDR_W'(unmap_off >> PAGE_BITS);

    // The ring index steps forward and wraps to zero after the last slot.
    assign idx_next = (r_ring_idx == ADDR_W'(SLOTS - 1)) ? '0 : r_ring_idx + 1'b1;

    // The slot offset and the page offset never overlap, so they are merged
    // and added to the window base in one adder.
    assign slot_off  = 64'(r_ring_idx) << PAGE_BITS;
    assign map_addr  = r_base + (slot_off[31:0] | 32'(r_pa[PAGE_BITS-1:0]));
    assign map_entry = {r_pa[31:PAGE_BITS], 1'b0, 1'b1};

    assign sweep_busy = (r_sweep < (ADDR_W + 1)'(SLOTS));
    assign out_free   = !r_m_valid || m_axis_tready;
    assign in_xfer    = s_axis_tvalid && s_axis_tready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_sweep == (ADDR_W + 1)'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (s_axis_tuser == KIND_UNMAP) ? S_UNMAP_RD : S_EPOCH;
                end
            end
            S_UNMAP_RD: begin
                n_state = unmap_in_range ? S_UNMAP_WR : S_IDLE;
            end
            S_UNMAP_WR: begin
                n_state = S_IDLE;
            end
            S_EPOCH: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (idx_next != '0) begin
                    n_state = S_CHECK;
                end else if (r_wrapped) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RECYCLE;
                end
            end
            S_RECYCLE: begin
                if (!sweep_busy && !r_rd_pend) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = ram_rdata[BIT_PRESENT] ? S_STEP : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Output and memory control logic.
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_ring_idx;
        ram_wdata     = map_entry;
        ram_raddr     = r_ring_idx;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep[ADDR_W-1:0];
                ram_wdata = '0;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_UNMAP_RD: begin
                ram_raddr = unmap_idx;
            end
            S_UNMAP_WR: begin
                // Read-modify-write keeps the frame and sets the ready flag,
                // whether or not the slot is present.
                ram_we    = 1'b1;
                ram_waddr = unmap_idx;
                ram_wdata = ram_rdata | ENTRY_W'(1 << BIT_READY);
            end
            S_STEP: begin
                ram_raddr = idx_next;
            end
            S_RECYCLE: begin
                // Read one slot per cycle; the slot read last cycle is
                // emptied if it was marked ready. When the sweep is over the
                // port reads the slot at the ring index, which is zero.
                ram_raddr = sweep_busy ? r_sweep[ADDR_W-1:0] : r_ring_idx;
                ram_we    = r_rd_pend && ram_rdata[BIT_READY];
                ram_waddr = r_rd_addr;
                ram_wdata = '0;
            end
            S_CHECK: begin
                ram_we    = !ram_rdata[BIT_PRESENT];
                ram_waddr = r_ring_idx;
                ram_wdata = map_entry;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_sweep        <= '0;
            r_rd_pend      <= 1'b0;
            r_base         <= '0;
            r_ring_idx     <= '0;
            r_global_epoch <= '0;
            for (int c = 0; c < CPUS; c++) begin
                r_cpu_epoch[c] <= '0;
            end
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end

            // The result register loads when the finished request finds it
            // free and empties when the receiver takes the transfer.
            if (r_state == S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_sweep <= (r_sweep == (ADDR_W + 1)'(SLOTS - 1)) ? '0 : r_sweep + 1'b1;
                end
                S_EPOCH: begin
                    if (r_cpu_epoch[r_cpu] != r_global_epoch) begin
                        r_cpu_epoch[r_cpu] <= r_global_epoch;
                    end
                end
                S_STEP: begin
                    r_ring_idx <= idx_next;
                    if (idx_next == '0 && !r_wrapped) begin
                        r_global_epoch     <= r_global_epoch + 1'b1;
                        r_cpu_epoch[r_cpu] <= r_global_epoch + 1'b1;
                        r_sweep            <= '0;
                        r_rd_pend          <= 1'b0;
                    end
                end
                S_RECYCLE: begin
                    r_rd_pend <= sweep_busy;
                    if (sweep_busy) begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RECYCLE) begin
            r_rd_addr <= r_sweep[ADDR_W-1:0];
        end

        if (in_xfer) begin
            r_cpu     <= cpu_wrap(s_axis_tdata[2:0]);
            r_pa      <= s_axis_tdata[34:3];
            r_va      <= s_axis_tdata[66:35];
            r_flush   <= 1'b0;
            r_wrapped <= 1'b0;
            r_full    <= 1'b0;
        end

        case (r_state)
            S_EPOCH: begin
                if (r_cpu_epoch[r_cpu] != r_global_epoch) begin
                    r_flush <= 1'b1;
                end
            end
            S_STEP: begin
                if (idx_next == '0) begin
                    r_flush <= 1'b1;
                    if (r_wrapped) begin
                        r_full     <= 1'b1;
                        r_res_addr <= '0;
                    end else begin
                        r_wrapped <= 1'b1;
                    end
                end
            end
            S_CHECK: begin
                r_res_addr <= map_addr;
            end
            S_DONE: begin
                if (out_free) begin
                    r_m_tdata <= {(M_TDATA_W - 43)'(0), r_flush,
                                  SLOT_IDX_W'(r_ring_idx), r_res_addr};
                    r_m_tuser <= r_full;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // A full ring reports a zero address and slot.
    a_full_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_full) |-> (r_res_addr == '0 && r_ring_idx == '0))
        else $error("full error with nonzero address or slot");

    // A wrap always raises the flush flag for the request.
    a_wrap_flush : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && n_state == S_RECYCLE) |=> (r_flush && r_wrapped))
        else $error("ring wrap without flush");

    // A map request never finishes before it has read a slot or wrapped twice.
    a_done_path : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE && n_state == S_DONE) |->
            (r_state == S_CHECK || (r_state == S_STEP && r_wrapped)))
        else $error("result produced without a slot check");

    // The epoch moves only on a recycle.
    a_epoch_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_STEP) |=> $stable(r_global_epoch))
        else $error("epoch changed outside a ring wrap");

endmodule
